@@ rtl/oams_pkg.sv @@
// shared types, codes and frame helpers for the obstacle avoiding motor sequencer
`timescale 1ns / 1ps
`default_nettype none
package oams_pkg;

  // motion states
  localparam logic [2:0] MS_STOP    = 3'd0;
  localparam logic [2:0] MS_FORWARD = 3'd1;
  localparam logic [2:0] MS_BRAKE   = 3'd2;
  localparam logic [2:0] MS_BACK    = 3'd3;
  localparam logic [2:0] MS_TURN    = 3'd4;

  // frame kinds carried through the queue
  localparam logic [2:0] FR_STOP   = 3'd0;
  localparam logic [2:0] FR_FWD    = 3'd1;
  localparam logic [2:0] FR_BACK   = 3'd2;
  localparam logic [2:0] FR_TURN_L = 3'd3;
  localparam logic [2:0] FR_TURN_R = 3'd4;

  // configuration register indexes
  localparam logic [7:0] CFG_STOP_DIST   = 8'd0;
  localparam logic [7:0] CFG_HIT_DEB     = 8'd1;
  localparam logic [7:0] CFG_BRAKE_TICKS = 8'd2;
  localparam logic [7:0] CFG_REV_TICKS   = 8'd3;
  localparam logic [7:0] CFG_SPIN_TICKS  = 8'd4;
  localparam logic [7:0] CFG_FWD_SPEED   = 8'd5;
  localparam logic [7:0] CFG_REV_SPEED   = 8'd6;
  localparam logic [7:0] CFG_SPIN_SPEED  = 8'd7;

  localparam logic [7:0]  FRAME_SOF    = 8'hFC;
  localparam logic [7:0]  FRAME_EOF    = 8'hFD;
  localparam logic [7:0]  SPEED_CAP    = 8'd150;
  localparam logic [14:0] ECHO_LIMIT   = 15'd30000;
  localparam logic [2:0]  FRAME_LAST   = 3'd5;
  localparam int          QDEPTH       = 4;

  typedef struct packed {
    logic [7:0] stop_distance_cm;
    logic [3:0] hit_limit;
    logic [7:0] brake_ticks;
    logic [7:0] reverse_ticks;
    logic [7:0] spin_ticks;
    logic [7:0] forward_speed;
    logic [7:0] reverse_speed;
    logic [7:0] spin_speed;
  } cfg_t;

  // one queued frame
  typedef struct packed {
    logic [2:0] kind;
    logic       last;
    logic [2:0] state;
  } entry_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] pend_cnt;
  } front_status_t;

  function automatic logic kind_lneg(input logic [2:0] kind);
    return (kind == FR_BACK) || (kind == FR_TURN_L);
  endfunction

  function automatic logic kind_rneg(input logic [2:0] kind);
    return (kind == FR_BACK) || (kind == FR_TURN_R);
  endfunction

  // one magnitude per frame kind, shared by both wheels before the back end scales and clamps it
  function automatic logic [7:0] kind_mag(input logic [2:0] kind, input cfg_t cfg);
    logic [7:0] m;
    case (kind)
      FR_FWD:    m = cfg.forward_speed;
      FR_BACK:   m = cfg.reverse_speed;
      FR_TURN_L: m = cfg.spin_speed;
      FR_TURN_R: m = cfg.spin_speed;
      default:   m = 8'd0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

@@ rtl/oams_front.sv @@
// front end: takes items, runs the motion state machine, queues frame kinds
`timescale 1ns / 1ps
`default_nettype none
module oams_front #(
  parameter int KEEPALIVE_PERIOD = 5
) (
  input  wire                     clk,
  input  wire                     rst,
  input  oams_pkg::cfg_t          cfg,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire                     in_command,
  input  wire  [14:0]             in_echo_us,
  input  wire                     in_no_echo,
  input  wire                     in_random_bit,
  output logic                    q_push,
  output oams_pkg::entry_t        q_entry,
  input  wire                     q_ready,
  output oams_pkg::front_status_t status
);
  import oams_pkg::*;

  localparam int PW = (KEEPALIVE_PERIOD > 1) ? $clog2(KEEPALIVE_PERIOD) : 1;

  logic [2:0]    mode, mode_next;
  logic [7:0]    ticks, ticks_next;
  logic [PW-1:0] phase, phase_next;
  logic [3:0]    hit, hit_next;
  logic          spin_left, spin_left_next;

  logic [8:0] pend;
  logic [1:0] pend_cnt;
  logic [2:0] pend_state;

  logic [8:0]  lst;
  logic [1:0]  n;
  logic [PW:0] phase_inc;
  logic [3:0]  hit_inc;
  logic [19:0] echo17;
  logic [19:0] stop1000;
  logic        obstacle;
  logic        accept;

  function automatic logic [8:0] frame_add(input logic [8:0] l, input logic [1:0] slot,
                                           input logic [2:0] k);
    logic [8:0] r;
    r = l;
    case (slot)
      2'd0:    r[2:0] = k;
      2'd1:    r[5:3] = k;
      default: r[8:6] = k;
    endcase
    return r;
  endfunction

  assign echo17   = 20'(in_echo_us) * 20'd17;
  assign stop1000 = 20'(cfg.stop_distance_cm) * 20'd1000;
  assign obstacle = !in_no_echo && (in_echo_us <= ECHO_LIMIT) && (echo17 < stop1000);
  assign hit_inc  = (hit != 4'hF) ? hit + 4'd1 : hit;
  assign phase_inc = {1'b0, phase} + (PW+1)'(1);

  always_comb begin
    lst            = '0;
    n              = 2'd0;
    mode_next      = mode;
    ticks_next     = ticks;
    phase_next     = phase;
    hit_next       = hit;
    spin_left_next = spin_left;
    if (!in_command) begin
      // start: restart forward from a clean slate
      mode_next      = MS_FORWARD;
      ticks_next     = 8'd0;
      phase_next     = '0;
      hit_next       = 4'd0;
      spin_left_next = 1'b0;
      lst = frame_add(lst, n, FR_FWD);
      n   = n + 2'd1;
    end else begin
      ticks_next = (ticks != 8'hFF) ? ticks + 8'd1 : ticks;
      phase_next = (phase_inc == (PW+1)'(KEEPALIVE_PERIOD)) ? '0 : phase_inc[PW-1:0];
      // keepalive resend, none while turning
      if (phase_next == '0) begin
        case (mode)
          MS_FORWARD: begin
            lst = frame_add(lst, n, FR_FWD);
            n   = n + 2'd1;
          end
          MS_BACK: begin
            lst = frame_add(lst, n, FR_BACK);
            n   = n + 2'd1;
          end
          MS_BRAKE, MS_STOP: begin
            lst = frame_add(lst, n, FR_STOP);
            n   = n + 2'd1;
          end
          default: begin
          end
        endcase
      end
      case (mode)
        MS_FORWARD: begin
          if (obstacle) begin
            hit_next = hit_inc;
            if (hit_inc >= cfg.hit_limit) begin
              mode_next  = MS_BRAKE;
              ticks_next = 8'd0;
              phase_next = '0;
              hit_next   = 4'd0;
              lst = frame_add(lst, n, FR_STOP);
              n   = n + 2'd1;
            end
          end else begin
            hit_next = 4'd0;
          end
        end
        MS_BRAKE: begin
          if (ticks_next >= cfg.brake_ticks) begin
            mode_next  = MS_BACK;
            ticks_next = 8'd0;
            phase_next = '0;
            lst = frame_add(lst, n, FR_BACK);
            n   = n + 2'd1;
          end
        end
        MS_BACK: begin
          lst = frame_add(lst, n, FR_BACK);
          n   = n + 2'd1;
          if (ticks_next >= cfg.reverse_ticks) begin
            spin_left_next = in_random_bit;
            mode_next      = MS_TURN;
            ticks_next     = 8'd0;
            phase_next     = '0;
            lst = frame_add(lst, n, in_random_bit ? FR_TURN_L : FR_TURN_R);
            n   = n + 2'd1;
          end
        end
        MS_TURN: begin
          lst = frame_add(lst, n, spin_left ? FR_TURN_L : FR_TURN_R);
          n   = n + 2'd1;
          if (ticks_next >= cfg.spin_ticks) begin
            mode_next  = MS_FORWARD;
            ticks_next = 8'd0;
            phase_next = '0;
            hit_next   = 4'd0;
            lst = frame_add(lst, n, FR_FWD);
            n   = n + 2'd1;
          end
        end
        default: begin
          lst = frame_add(lst, n, FR_STOP);
          n   = n + 2'd1;
          mode_next  = MS_FORWARD;
          ticks_next = 8'd0;
          phase_next = '0;
        end
      endcase
    end
  end

  // pending list drains one frame per cycle into the queue while the queue is not full
  assign q_push        = (pend_cnt != 2'd0) && q_ready;
  assign q_entry.kind  = pend[2:0];
  assign q_entry.last  = (pend_cnt == 2'd1);
  assign q_entry.state = pend_state;

  assign in_ready = (pend_cnt == 2'd0) || ((pend_cnt == 2'd1) && q_push);
  assign accept   = in_valid && in_ready;

  assign status.mode     = mode;
  assign status.pend_cnt = pend_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MS_STOP;
      ticks     <= 8'd0;
      phase     <= '0;
      hit       <= 4'd0;
      spin_left <= 1'b0;
      pend_cnt  <= 2'd0;
    end else if (accept) begin
      mode      <= mode_next;
      ticks     <= ticks_next;
      phase     <= phase_next;
      hit       <= hit_next;
      spin_left <= spin_left_next;
      pend_cnt  <= n;
    end else if (q_push) begin
      pend_cnt <= pend_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend       <= lst;
      pend_state <= mode_next;
    end else if (q_push) begin
      pend <= {3'd0, pend[8:3]};
    end
  end

endmodule
`default_nettype wire

@@ rtl/oams_fifo.sv @@
// small frame queue between the front end and the serializer
`timescale 1ns / 1ps
`default_nettype none
module oams_fifo (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  oams_pkg::entry_t  wr_entry,
  output logic              not_full,
  input  wire               pop,
  output oams_pkg::entry_t  rd_entry,
  output logic              not_empty
);
  import oams_pkg::*;

  localparam int AW = $clog2(QDEPTH);

  entry_t        mem [QDEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;

  assign not_full  = (count != (AW+1)'(QDEPTH));
  assign not_empty = (count != '0);
  assign rd_entry  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + AW'(1);
      if (pop)  rptr <= rptr + AW'(1);
      if (push && !pop) count <= count + (AW+1)'(1);
      else if (pop && !push) count <= count - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_entry;
  end

endmodule
`default_nettype wire

@@ rtl/oams_back.sv @@
// back end: expands queued frame kinds into six-byte motor frames
`timescale 1ns / 1ps
`default_nettype none
module oams_back #(
  parameter int RIGHT_COMP_PERCENT = 15
) (
  input  wire               clk,
  input  wire               rst,
  input  oams_pkg::cfg_t    cfg,
  input  wire               q_valid,
  input  oams_pkg::entry_t  q_entry,
  output logic              q_pop,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic [2:0]        out_state
);
  import oams_pkg::*;

  localparam logic [7:0]  COMP  = 8'(100 + RIGHT_COMP_PERCENT);
  // floor(x/100) as (x*RECIP)>>23, exact for x below 2^16
  localparam int          SHIFT = 23;
  localparam logic [32:0] RECIP = 33'(((2 ** SHIFT) + 99) / 100);

  entry_t      cur;
  logic        cur_valid;
  logic [2:0]  idx;
  logic [15:0] prod1;
  logic [32:0] qprod;
  logic [8:0]  quot;
  logic [7:0]  r_scaled;
  logic [7:0]  mag;
  logic [7:0]  l_clamp;
  logic        emit;
  logic        done;
  logic [7:0]  byte_sel;

  assign emit  = cur_valid && (!out_valid || out_ready);
  assign done  = emit && (idx == FRAME_LAST);
  assign q_pop = q_valid && (!cur_valid || done);

  assign mag     = kind_mag(cur.kind, cfg);
  assign l_clamp = (mag > SPEED_CAP) ? SPEED_CAP : mag;
  assign qprod   = 33'(prod1) * RECIP;
  assign quot    = qprod[SHIFT+8:SHIFT];

  always_comb begin
    case (idx)
      3'd0:    byte_sel = FRAME_SOF;
      3'd1:    byte_sel = {7'd0, kind_lneg(cur.kind) && (mag != 8'd0)};
      3'd2:    byte_sel = l_clamp;
      3'd3:    byte_sel = {7'd0, kind_rneg(cur.kind) && (mag != 8'd0)};
      3'd4:    byte_sel = r_scaled;
      default: byte_sel = FRAME_EOF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) cur_valid <= 1'b1;
      else if (done) cur_valid <= 1'b0;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur   <= q_entry;
      idx   <= 3'd0;
      prod1 <= 16'(kind_mag(q_entry.kind, cfg)) * 16'(COMP);
    end else if (emit) begin
      idx <= idx + 3'd1;
    end
    r_scaled <= (quot > 9'(SPEED_CAP)) ? SPEED_CAP : quot[7:0];
    if (emit) begin
      out_byte  <= byte_sel;
      out_last  <= cur.last && (idx == FRAME_LAST);
      out_state <= cur.state;
    end
  end

endmodule
`default_nettype wire

@@ rtl/obstacle_avoid_motor_sequencer.sv @@
// top level of the obstacle avoiding motor sequencer
//
//  channel   dir   handshake                  payload
//  s_axis    in    s_axis_tvalid/tready      tuser command, tdata echo/no_echo/random
//  m_axis    out   m_axis_tvalid/tready      tdata frame byte, tlast, tuser state
//  cfg       in    cfg_valid/cfg_ready       cfg_index, cfg_data
//
// an item is taken in one cycle; its frames (zero to three) leave one byte per
// cycle from the serializer while m_axis_tready is high, six bytes per frame
// a four-deep frame queue lets the front end take the next item while bytes drain
// m_axis_tready low holds the current byte; the front end hands one frame per cycle
// to the queue, so an item with several frames holds off the next one until its
// last frame is being handed over, and longer while the queue is full
// rst (synchronous) puts the car in stop and restores the register defaults
`timescale 1ns / 1ps
`default_nettype none
module obstacle_avoid_motor_sequencer #(
  parameter int KEEPALIVE_PERIOD   = 5,
  parameter int RIGHT_COMP_PERCENT = 15
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // [14:0] echo_us, [15] no_echo, [16] random_bit
  input  wire         s_axis_tuser,   // [0] command: 0 start, 1 tick
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
  output logic        m_axis_tlast,
  output logic [2:0]  m_axis_tuser,   // [2:0] motion_state
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [7:0]  cfg_index,
  input  wire  [7:0]  cfg_data
);
  import oams_pkg::*;

  cfg_t          cfg;
  entry_t        push_entry;
  entry_t        head_entry;
  front_status_t fstat;
  logic          q_push;
  logic          q_not_full;
  logic          q_pop;
  logic          q_not_empty;

  // configuration registers, always ready; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_distance_cm <= 8'd10;
      cfg.hit_limit        <= 4'd2;
      cfg.brake_ticks      <= 8'd3;
      cfg.reverse_ticks    <= 8'd15;
      cfg.spin_ticks       <= 8'd50;
      cfg.forward_speed    <= 8'd70;
      cfg.reverse_speed    <= 8'd70;
      cfg.spin_speed       <= 8'd70;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STOP_DIST:   cfg.stop_distance_cm <= cfg_data;
        CFG_HIT_DEB:     cfg.hit_limit        <= cfg_data[3:0];
        CFG_BRAKE_TICKS: cfg.brake_ticks      <= cfg_data;
        CFG_REV_TICKS:   cfg.reverse_ticks    <= cfg_data;
        CFG_SPIN_TICKS:  cfg.spin_ticks       <= cfg_data;
        CFG_FWD_SPEED:   cfg.forward_speed    <= cfg_data;
        CFG_REV_SPEED:   cfg.reverse_speed    <= cfg_data;
        CFG_SPIN_SPEED:  cfg.spin_speed       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // state machine and frame selection
  oams_front #(
    .KEEPALIVE_PERIOD (KEEPALIVE_PERIOD)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_command    (s_axis_tuser),
    .in_echo_us    (s_axis_tdata[14:0]),
    .in_no_echo    (s_axis_tdata[15]),
    .in_random_bit (s_axis_tdata[16]),
    .q_push        (q_push),
    .q_entry       (push_entry),
    .q_ready       (q_not_full),
    .status        (fstat)
  );

  // frame queue
  oams_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_entry  (push_entry),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .rd_entry  (head_entry),
    .not_empty (q_not_empty)
  );

  // byte serializer with right wheel compensation
  oams_back #(
    .RIGHT_COMP_PERCENT (RIGHT_COMP_PERCENT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_not_empty),
    .q_entry   (head_entry),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_state (m_axis_tuser)
  );

  // a start transfer always lands in forward
  a_start_forward: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> fstat.mode == MS_FORWARD)
    else $error("start did not enter forward");

  // the last byte of an item closes a frame
  a_last_is_eof: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == FRAME_EOF)
    else $error("last byte is not an end of frame");

  // the front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fstat.pend_cnt != 2'd0 && !q_not_full |-> !q_push)
    else $error("frame queue overflow");

endmodule
`default_nettype wire
